### rtl/core/smith_predictor_controller_unit_assert.svh
// Assertion macros for the Smith predictor controller.
// Used by the top level; depends on nothing else.
`ifndef SMITH_PREDICTOR_CONTROLLER_UNIT_ASSERT_SVH
`define SMITH_PREDICTOR_CONTROLLER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SPC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/spc_pkg.sv
// Shared constants, codes and saturation helper for the Smith predictor controller.
// No dependencies.
package spc_pkg;

    localparam int DATA_W    = 32;
    localparam int PROD_W    = 48;
    localparam int ACC_W     = 56;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE            = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_STEPS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_A          = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_B          = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_C          = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT_WEIGHT = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_DT         = 3'd7;

    localparam logic [1:0] MODE_PID     = 2'd0;
    localparam logic [1:0] MODE_LEADLAG = 2'd1;

    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_COEF   = 1'b1;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [ACC_W-1:0]  acc_t;

    function automatic data_t sat32(input acc_t v);
        data_t r;
        if (v[ACC_W-1:DATA_W-1] == {(ACC_W-DATA_W+1){1'b0}} ||
            v[ACC_W-1:DATA_W-1] == {(ACC_W-DATA_W+1){1'b1}})
        begin
            r = v[DATA_W-1:0];
        end
        else if (v[ACC_W-1])
        begin
            r = {1'b1, {(DATA_W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(DATA_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

### rtl/core/spc_if.sv
// Valid/ready channel interfaces for the Smith predictor controller.
// Depends on spc_pkg.
interface spc_in_if;
    logic                 valid;
    logic                 ready;
    logic                 action;
    logic [4:0]           coef_index;
    spc_pkg::data_t       sample_value;

    modport source (output valid, output action, output coef_index, output sample_value,
                    input ready);
    modport sink (input valid, input action, input coef_index, input sample_value,
                  output ready);
endinterface

interface spc_out_if;
    logic                 valid;
    logic                 ready;
    spc_pkg::data_t       control_value;
    spc_pkg::data_t       model_output;
    spc_pkg::data_t       loop_error;

    modport source (output valid, output control_value, output model_output,
                    output loop_error, input ready);
    modport sink (input valid, input control_value, input model_output,
                  input loop_error, output ready);
endinterface

### rtl/core/spc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module spc_ram #(
    parameter int W     = 32,
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [W-1:0]  wdata,
    input  logic [AW-1:0] raddr,
    output logic [W-1:0]  rdata
);

    logic [W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/spc_mul.sv
// Shared Q16.16 multiplier with round-half-up and a registered product.
// Depends on spc_pkg.
module spc_mul (
    input  logic           clk,
    input  spc_pkg::data_t a,
    input  spc_pkg::data_t b,
    output spc_pkg::prod_t prod_reg
);

    logic signed [63:0] full;

    assign full = (64'(a) * 64'(b)) + 64'sd32768;

    always_ff @(posedge clk)
    begin
        prod_reg <= full[63:16];
    end

endmodule

### rtl/core/smith_predictor_controller_unit.sv
// Smith predictor controller: model MACs on one shared multiplier, ring of past predictions.
// Depends on spc_pkg, spc_if, spc_ram, spc_mul and the assertion header.
//
// Usage: items arrive on in_ch. An item with action set writes one model
// coefficient (A row-major, then B, then C) and yields no transaction on
// out_ch; an index beyond the C coefficients writes nothing. A plant sample
// yields one transaction on out_ch with the drive, the undelayed model
// prediction and the corrected error. Configuration registers are written
// through cfg_we, cfg_index and cfg_data; the user must write them only
// while the block is idle, which the block itself does not enforce.
// The model multiply-accumulates all go through one multiplier and read
// their coefficients from the coefficient memory, one term after another.
// One item is processed at a time.
// Reset clears the model state, the controller state, the ring fill count
// and the coefficient valid bits, so all of them read as zero.
// When the receiver stalls, the finished result waits in the output
// register; the next sample is accepted and computed, then holds in its
// last step until the output register is free.
module smith_predictor_controller_unit #(
    parameter int MODEL_ORDER = 4,
    parameter int RING_DEPTH  = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    spc_in_if.sink                        in_ch,
    spc_out_if.source                     out_ch,
    input  logic                          cfg_we,
    input  logic [spc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [spc_pkg::DATA_W-1:0]    cfg_data
);

    localparam int N      = MODEL_ORDER;
    localparam int NCOEF  = N * N + 2 * N;
    localparam int B_BASE = N * N;
    localparam int C_BASE = N * N + N;
    localparam int CAW    = $clog2(NCOEF);
    localparam int CIW    = (CAW > 5) ? CAW : 5;
    localparam int IW     = $clog2(N + 1);
    localparam int XW     = (N > 1) ? $clog2(N) : 1;
    localparam int PTR_W  = $clog2(RING_DEPTH);
    localparam int CNT_W  = $clog2(RING_DEPTH + 1);
    localparam int DW     = ((CNT_W > 7) ? CNT_W : 7) + 1;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_MAC_MUL = 4'd1;
    localparam logic [3:0] S_MAC_ACC = 4'd2;
    localparam logic [3:0] S_RING    = 4'd3;
    localparam logic [3:0] S_YC      = 4'd4;
    localparam logic [3:0] S_ERR     = 4'd5;
    localparam logic [3:0] S_C0      = 4'd6;
    localparam logic [3:0] S_C1      = 4'd7;
    localparam logic [3:0] S_C2      = 4'd8;
    localparam logic [3:0] S_C3      = 4'd9;
    localparam logic [3:0] S_C4      = 4'd10;
    localparam logic [3:0] S_C5      = 4'd11;
    localparam logic [3:0] S_UPD_MUL = 4'd12;
    localparam logic [3:0] S_UPD_ACC = 4'd13;
    localparam logic [3:0] S_DONE    = 4'd14;

    localparam logic PH_PRED  = 1'b0;
    localparam logic PH_MODEL = 1'b1;

    logic [3:0]             state_reg;
    logic                   phase_reg;
    logic [XW-1:0]          i_reg;
    logic [IW-1:0]          j_reg;
    logic [CAW-1:0]         coef_addr_reg;
    logic [CAW-1:0]         coef_addr_next;
    logic [NCOEF-1:0]       coef_vld_reg;
    spc_pkg::acc_t          acc_reg;
    spc_pkg::data_t         y_reg;
    spc_pkg::data_t         pred_reg;
    spc_pkg::data_t         ycorr_reg;
    spc_pkg::data_t         err_reg;
    spc_pkg::data_t         inner_reg;
    spc_pkg::data_t         diff_reg;
    spc_pkg::data_t         u_reg;
    spc_pkg::data_t         integ_reg;
    spc_pkg::data_t         last_err_reg;
    spc_pkg::data_t         last_drive_reg;
    spc_pkg::data_t         x_reg [N];
    spc_pkg::data_t         dx_reg [N];
    logic [PTR_W-1:0]       wp_reg;
    logic [CNT_W-1:0]       fill_reg;
    logic                   dly_fwd_reg;
    logic                   dly_ok_reg;
    logic                   out_valid_reg;
    spc_pkg::data_t         out_u_reg;
    spc_pkg::data_t         out_pred_reg;
    spc_pkg::data_t         out_err_reg;

    logic [1:0]             mode_reg;
    spc_pkg::data_t         setpoint_reg;
    logic [6:0]             delay_steps_reg;
    spc_pkg::data_t         coef_a_reg;
    spc_pkg::data_t         coef_b_reg;
    spc_pkg::data_t         coef_c_reg;
    spc_pkg::data_t         sp_weight_reg;
    logic [30:0]            step_dt_reg;

    logic                   in_acc;
    logic                   coef_we;
    logic [spc_pkg::DATA_W-1:0] coef_rdata;
    spc_pkg::data_t         coef_m;
    logic [spc_pkg::DATA_W-1:0] ring_rdata;
    logic [PTR_W-1:0]       ring_raddr;
    logic [DW-1:0]          d_eff;
    logic [DW-1:0]          rd_sum;
    logic [CNT_W-1:0]       fill_next;
    logic [PTR_W-1:0]       wp_next;
    spc_pkg::data_t         mul_a;
    spc_pkg::data_t         mul_b;
    spc_pkg::prod_t         prod;
    spc_pkg::acc_t          mac_sum;
    spc_pkg::data_t         delayed;
    logic [XW-1:0]          jx;
    logic                   is_pid;
    logic                   out_free;

    assign in_acc   = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == S_IDLE);
    assign coef_we  = in_acc && (in_ch.action == spc_pkg::ACT_COEF) &&
                      (CIW'(in_ch.coef_index) < CIW'(NCOEF));
    assign coef_m   = coef_vld_reg[coef_addr_reg] ? coef_rdata : '0;
    assign jx       = j_reg[XW-1:0];
    assign is_pid   = (mode_reg == spc_pkg::MODE_PID);
    assign out_free = !out_valid_reg || out_ch.ready;

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.control_value   = out_u_reg;
    assign out_ch.model_output    = out_pred_reg;
    assign out_ch.loop_error      = out_err_reg;

    spc_ram #(.W(spc_pkg::DATA_W), .DEPTH(NCOEF)) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (CAW'(in_ch.coef_index)),
        .wdata (in_ch.sample_value),
        .raddr (coef_addr_next),
        .rdata (coef_rdata)
    );

    spc_ram #(.W(spc_pkg::DATA_W), .DEPTH(RING_DEPTH)) u_ring_ram (
        .clk   (clk),
        .we    (state_reg == S_RING),
        .waddr (wp_reg),
        .wdata (pred_reg),
        .raddr (ring_raddr),
        .rdata (ring_rdata)
    );

    spc_mul u_mul (
        .clk      (clk),
        .a        (mul_a),
        .b        (mul_b),
        .prod_reg (prod)
    );

    always_comb
    begin
        if (delay_steps_reg == 7'd0)
        begin
            d_eff = DW'(1);
        end
        else if (DW'(delay_steps_reg) > DW'(RING_DEPTH))
        begin
            d_eff = DW'(RING_DEPTH);
        end
        else
        begin
            d_eff = DW'(delay_steps_reg);
        end
        rd_sum = DW'(wp_reg) + DW'(1) + DW'(RING_DEPTH) - d_eff;
        if (rd_sum >= DW'(RING_DEPTH))
        begin
            ring_raddr = PTR_W'(rd_sum - DW'(RING_DEPTH));
        end
        else
        begin
            ring_raddr = PTR_W'(rd_sum);
        end
        fill_next = (fill_reg == CNT_W'(RING_DEPTH)) ? fill_reg : fill_reg + CNT_W'(1);
        wp_next   = (wp_reg == PTR_W'(RING_DEPTH - 1)) ? '0 : wp_reg + PTR_W'(1);
        delayed   = dly_fwd_reg ? pred_reg : (dly_ok_reg ? ring_rdata : '0);
        mac_sum   = ((j_reg == '0) ? spc_pkg::acc_t'(0) : acc_reg) + spc_pkg::acc_t'(prod);
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_MAC_MUL:
            begin
                mul_a = coef_m;
                mul_b = (phase_reg == PH_MODEL && j_reg == IW'(N)) ? u_reg : x_reg[jx];
            end
            S_ERR:
            begin
                mul_a = sp_weight_reg;
                mul_b = setpoint_reg;
            end
            S_C0:
            begin
                mul_a = coef_a_reg;
                mul_b = last_drive_reg;
            end
            S_C1:
            begin
                mul_a = is_pid ? coef_a_reg : coef_b_reg;
                mul_b = is_pid ? inner_reg : err_reg;
            end
            S_C2:
            begin
                mul_a = coef_c_reg;
                mul_b = is_pid ? diff_reg : last_err_reg;
            end
            S_C3:
            begin
                mul_a = coef_b_reg;
                mul_b = err_reg;
            end
            S_UPD_MUL:
            begin
                mul_a = dx_reg[jx];
                mul_b = {1'b0, step_dt_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        coef_addr_next = coef_addr_reg;
        case (state_reg)
            S_IDLE:
            begin
                coef_addr_next = CAW'(C_BASE);
            end
            S_MAC_ACC:
            begin
                if (phase_reg == PH_PRED)
                begin
                    coef_addr_next = CAW'(C_BASE + int'(j_reg) + 1);
                end
                else if (j_reg == IW'(N))
                begin
                    coef_addr_next = CAW'((int'(i_reg) + 1) * N);
                end
                else if (j_reg == IW'(N - 1))
                begin
                    coef_addr_next = CAW'(B_BASE + int'(i_reg));
                end
                else
                begin
                    coef_addr_next = CAW'(int'(i_reg) * N + int'(j_reg) + 1);
                end
            end
            S_C5:
            begin
                coef_addr_next = '0;
            end
            default:
            begin
                coef_addr_next = coef_addr_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= '0;
            setpoint_reg    <= '0;
            delay_steps_reg <= 7'd1;
            coef_a_reg      <= '0;
            coef_b_reg      <= '0;
            coef_c_reg      <= '0;
            sp_weight_reg   <= '0;
            step_dt_reg     <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                spc_pkg::CFG_MODE:            mode_reg        <= cfg_data[1:0];
                spc_pkg::CFG_SETPOINT:        setpoint_reg    <= cfg_data;
                spc_pkg::CFG_DELAY_STEPS:     delay_steps_reg <= cfg_data[6:0];
                spc_pkg::CFG_COEF_A:          coef_a_reg      <= cfg_data;
                spc_pkg::CFG_COEF_B:          coef_b_reg      <= cfg_data;
                spc_pkg::CFG_COEF_C:          coef_c_reg      <= cfg_data;
                spc_pkg::CFG_SETPOINT_WEIGHT: sp_weight_reg   <= cfg_data;
                spc_pkg::CFG_STEP_DT:         step_dt_reg     <= cfg_data[30:0];
                default:                      mode_reg        <= mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            phase_reg      <= PH_PRED;
            i_reg          <= '0;
            j_reg          <= '0;
            coef_addr_reg  <= '0;
            coef_vld_reg   <= '0;
            wp_reg         <= '0;
            fill_reg       <= '0;
            integ_reg      <= '0;
            last_err_reg   <= '0;
            last_drive_reg <= '0;
            out_valid_reg  <= 1'b0;
            for (int k = 0; k < N; k++)
            begin
                x_reg[k] <= '0;
            end
        end
        else
        begin
            coef_addr_reg <= coef_addr_next;
            if (out_valid_reg && out_ch.ready && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            if (coef_we)
            begin
                coef_vld_reg[CAW'(in_ch.coef_index)] <= 1'b1;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc && in_ch.action == spc_pkg::ACT_SAMPLE)
                    begin
                        y_reg     <= in_ch.sample_value;
                        phase_reg <= PH_PRED;
                        j_reg     <= '0;
                        state_reg <= S_MAC_MUL;
                    end
                end
                S_MAC_MUL:
                begin
                    state_reg <= S_MAC_ACC;
                end
                S_MAC_ACC:
                begin
                    acc_reg <= mac_sum;
                    if (phase_reg == PH_PRED)
                    begin
                        if (j_reg == IW'(N - 1))
                        begin
                            pred_reg  <= spc_pkg::sat32(mac_sum);
                            state_reg <= S_RING;
                        end
                        else
                        begin
                            j_reg     <= j_reg + IW'(1);
                            state_reg <= S_MAC_MUL;
                        end
                    end
                    else if (j_reg == IW'(N))
                    begin
                        dx_reg[i_reg] <= spc_pkg::sat32(mac_sum);
                        j_reg         <= '0;
                        if (i_reg == XW'(N - 1))
                        begin
                            state_reg <= S_UPD_MUL;
                        end
                        else
                        begin
                            i_reg     <= i_reg + XW'(1);
                            state_reg <= S_MAC_MUL;
                        end
                    end
                    else
                    begin
                        j_reg     <= j_reg + IW'(1);
                        state_reg <= S_MAC_MUL;
                    end
                end
                S_RING:
                begin
                    wp_reg      <= wp_next;
                    fill_reg    <= fill_next;
                    dly_fwd_reg <= (d_eff == DW'(1));
                    dly_ok_reg  <= (DW'(fill_next) >= d_eff);
                    state_reg   <= S_YC;
                end
                S_YC:
                begin
                    ycorr_reg <= spc_pkg::sat32(spc_pkg::acc_t'(y_reg) +
                                 spc_pkg::acc_t'(pred_reg) - spc_pkg::acc_t'(delayed));
                    state_reg <= S_ERR;
                end
                S_ERR:
                begin
                    err_reg   <= spc_pkg::sat32(spc_pkg::acc_t'(setpoint_reg) -
                                 spc_pkg::acc_t'(ycorr_reg));
                    state_reg <= S_C0;
                end
                S_C0:
                begin
                    inner_reg <= spc_pkg::sat32(spc_pkg::acc_t'(prod) -
                                 spc_pkg::acc_t'(ycorr_reg));
                    diff_reg  <= spc_pkg::sat32(spc_pkg::acc_t'(err_reg) -
                                 spc_pkg::acc_t'(last_err_reg));
                    state_reg <= S_C1;
                end
                S_C1:
                begin
                    acc_reg   <= spc_pkg::acc_t'(prod);
                    state_reg <= S_C2;
                end
                S_C2:
                begin
                    acc_reg   <= is_pid ? spc_pkg::acc_t'(prod) :
                                 acc_reg + spc_pkg::acc_t'(prod);
                    state_reg <= S_C3;
                end
                S_C3:
                begin
                    acc_reg   <= acc_reg + spc_pkg::acc_t'(prod);
                    state_reg <= S_C4;
                end
                S_C4:
                begin
                    if (is_pid)
                    begin
                        integ_reg <= spc_pkg::sat32(spc_pkg::acc_t'(integ_reg) +
                                     spc_pkg::acc_t'(prod));
                    end
                    state_reg <= S_C5;
                end
                S_C5:
                begin
                    if (is_pid)
                    begin
                        u_reg        <= spc_pkg::sat32(acc_reg + spc_pkg::acc_t'(integ_reg));
                        last_err_reg <= err_reg;
                    end
                    else if (mode_reg == spc_pkg::MODE_LEADLAG)
                    begin
                        u_reg          <= spc_pkg::sat32(acc_reg);
                        last_drive_reg <= spc_pkg::sat32(acc_reg);
                        last_err_reg   <= err_reg;
                    end
                    else
                    begin
                        u_reg <= '0;
                    end
                    phase_reg <= PH_MODEL;
                    i_reg     <= '0;
                    j_reg     <= '0;
                    state_reg <= S_MAC_MUL;
                end
                S_UPD_MUL:
                begin
                    state_reg <= S_UPD_ACC;
                end
                S_UPD_ACC:
                begin
                    x_reg[jx] <= spc_pkg::sat32(spc_pkg::acc_t'(x_reg[jx]) +
                                 spc_pkg::acc_t'(prod));
                    if (j_reg == IW'(N - 1))
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        j_reg     <= j_reg + IW'(1);
                        state_reg <= S_UPD_MUL;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_u_reg     <= u_reg;
                        out_pred_reg  <= pred_reg;
                        out_err_reg   <= err_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`include "smith_predictor_controller_unit_assert.svh"

    `SPC_ASSERT_NEXT(a_done_holds, clk, rst_n,
        state_reg == S_DONE && out_valid_reg && !out_ch.ready,
        state_reg == S_DONE, "Result finished while the output register was still full.")
    `SPC_ASSERT_NOW(a_fill_bound, clk, rst_n, 1'b1,
        fill_reg <= CNT_W'(RING_DEPTH), "Ring fill count exceeds the ring depth.")
    `SPC_ASSERT_NEXT(a_sample_starts, clk, rst_n,
        in_acc && in_ch.action == spc_pkg::ACT_SAMPLE,
        state_reg == S_MAC_MUL && phase_reg == PH_PRED, "Sample did not start the prediction.")
    `SPC_ASSERT_NEXT(a_coef_no_result, clk, rst_n,
        in_acc && in_ch.action == spc_pkg::ACT_COEF,
        state_reg == S_IDLE && !$rose(out_valid_reg), "Coefficient write produced a result.")

endmodule

### tb/smith_predictor_controller_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the Smith predictor controller unit.
// Depends on spc_pkg, spc_if and the RTL; predicts each sample result and compares it.
module smith_predictor_controller_unit_test;

    localparam int ORDER = 4;
    localparam int DEPTH = 64;
    localparam int NCOEF = ORDER * ORDER + 2 * ORDER;
    localparam int BBASE = ORDER * ORDER;
    localparam int CBASE = ORDER * ORDER + ORDER;
    localparam int LATENCY = 2 * NCOEF + 2 * ORDER + 10;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int CALM_TAIL = 150;

    typedef struct packed {
        logic        action;
        logic [4:0]  coef_index;
        logic [31:0] sample_value;
    } item_t;

    typedef struct packed {
        logic [31:0] control_value;
        logic [31:0] model_output;
        logic [31:0] loop_error;
    } result_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [spc_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [spc_pkg::DATA_W-1:0] cfg_data;

    spc_in_if in_ch();
    spc_out_if out_ch();

    smith_predictor_controller_unit dut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    logic [1:0] ctl_mode;
    logic signed [31:0] ctl_setpoint, ctl_a, ctl_b, ctl_c, ctl_weight;
    logic [6:0] ctl_delay;
    logic [30:0] ctl_dt;
    logic signed [31:0] model_x [ORDER];
    logic signed [31:0] past_pred [DEPTH];
    int unsigned ring_slot;
    logic signed [31:0] coefs [NCOEF];
    logic signed [31:0] integ, prev_err, prev_drive;

    item_t pending_items[$];
    result_t expected_results[$];
    int errors = 0;
    int samples_checked = 0;
    int idle_cycles = 0;
    bit calm = 0;
    int in_gap = 0;
    int out_gap = 0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [63:0] qprod(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b) + 64'sd32768;
        return p >>> 16;
    endfunction

    task automatic write_register(input logic [spc_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            spc_pkg::CFG_MODE: ctl_mode = val[1:0];
            spc_pkg::CFG_SETPOINT: ctl_setpoint = val;
            spc_pkg::CFG_DELAY_STEPS: ctl_delay = val[6:0];
            spc_pkg::CFG_COEF_A: ctl_a = val;
            spc_pkg::CFG_COEF_B: ctl_b = val;
            spc_pkg::CFG_COEF_C: ctl_c = val;
            spc_pkg::CFG_SETPOINT_WEIGHT: ctl_weight = val;
            spc_pkg::CFG_STEP_DT: ctl_dt = val[30:0];
            default: ;
        endcase
    endtask

    task automatic predict_transaction(input item_t it);
        logic signed [63:0] acc, pterm, dterm;
        logic signed [31:0] y, pred, delayed, ycorr, err, inner, u;
        logic signed [31:0] dx [ORDER];
        int unsigned d, rd;
        result_t r;
        y = it.sample_value;
        if (it.action == spc_pkg::ACT_COEF)
        begin
            if (it.coef_index < NCOEF)
                coefs[it.coef_index] = y;
            return;
        end
        acc = 0;
        for (int j = 0; j < ORDER; j++)
            acc += qprod(coefs[CBASE + j], model_x[j]);
        pred = clamp32(acc);
        past_pred[ring_slot] = pred;
        ring_slot = (ring_slot + 1) % DEPTH;
        d = ctl_delay;
        if (d < 1)
            d = 1;
        if (d > DEPTH)
            d = DEPTH;
        rd = (ring_slot + DEPTH - d) % DEPTH;
        delayed = past_pred[rd];
        ycorr = clamp32(64'(y) + 64'(pred) - 64'(delayed));
        err = clamp32(64'(ctl_setpoint) - 64'(ycorr));
        u = 0;
        if (ctl_mode == spc_pkg::MODE_PID)
        begin
            inner = clamp32(qprod(ctl_weight, ctl_setpoint) - 64'(ycorr));
            pterm = qprod(ctl_a, inner);
            dterm = qprod(ctl_c, clamp32(64'(err) - 64'(prev_err)));
            integ = clamp32(64'(integ) + qprod(ctl_b, err));
            u = clamp32(pterm + 64'(integ) + dterm);
            prev_err = err;
        end
        else if (ctl_mode == spc_pkg::MODE_LEADLAG)
        begin
            u = clamp32(qprod(ctl_a, prev_drive) + qprod(ctl_b, err) + qprod(ctl_c, prev_err));
            prev_drive = u;
            prev_err = err;
        end
        for (int i = 0; i < ORDER; i++)
        begin
            acc = 0;
            for (int j = 0; j < ORDER; j++)
                acc += qprod(coefs[i * ORDER + j], model_x[j]);
            acc += qprod(coefs[BBASE + i], u);
            dx[i] = clamp32(acc);
        end
        for (int i = 0; i < ORDER; i++)
            model_x[i] = clamp32(64'(model_x[i]) + qprod(dx[i], $signed({1'b0, ctl_dt})));
        r.control_value = u;
        r.model_output = pred;
        r.loop_error = err;
        expected_results.push_back(r);
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        $display("mismatch on %s at %0t: got %h, expected %h", field, $realtime, got, want);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.action <= spc_pkg::ACT_SAMPLE;
            in_ch.coef_index <= '0;
            in_ch.sample_value <= '0;
            in_gap <= 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                predict_transaction({in_ch.action, in_ch.coef_index, in_ch.sample_value});
            if (!in_ch.valid || in_ch.ready)
            begin
                if (in_gap > 0)
                begin
                    in_gap <= in_gap - 1;
                    in_ch.valid <= 1'b0;
                end
                else if (pending_items.size() > 0 && !(!calm && $urandom_range(0, 9) == 0))
                begin
                    item_t nxt;
                    nxt = pending_items.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.action <= nxt.action;
                    in_ch.coef_index <= nxt.coef_index;
                    in_ch.sample_value <= nxt.sample_value;
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                    if (!calm && pending_items.size() > 0)
                        in_gap <= $urandom_range(1, 12);
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            out_gap <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("transaction with no expected result at %0t", $realtime);
                end
                else
                begin
                    result_t want;
                    want = expected_results.pop_front();
                    samples_checked++;
                    if (out_ch.control_value !== want.control_value)
                        report_mismatch("control_value", out_ch.control_value, want.control_value);
                    if (out_ch.model_output !== want.model_output)
                        report_mismatch("model_output", out_ch.model_output, want.model_output);
                    if (out_ch.loop_error !== want.loop_error)
                        report_mismatch("loop_error", out_ch.loop_error, want.loop_error);
                end
            end
            if (out_gap > 0)
            begin
                out_gap <= out_gap - 1;
                out_ch.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 15) == 0)
            begin
                out_gap <= $urandom_range(1, 12) - 1;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[smith_predictor_controller_unit] ERROR");
            $finish;
        end
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h00000000;
            3: return $urandom();
            default: return 32'($signed($urandom_range(0, 8 * 65536)) - 4 * 65536);
        endcase
    endfunction

    function automatic item_t make_item(input logic act, input logic [4:0] idx,
                                        input logic [31:0] val);
        item_t it;
        it.action = act;
        it.coef_index = idx;
        it.sample_value = val;
        return it;
    endfunction

    task automatic wait_drained();
        while (pending_items.size() > 0 || in_ch.valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    task automatic random_phase(input int count);
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 5) == 0)
                pending_items.push_back(make_item(spc_pkg::ACT_COEF,
                                                  5'($urandom_range(0, 31)),
                                                  $urandom_range(0, 3) == 0 ? $urandom()
                                                  : 32'($signed($urandom_range(0, 32768)) - 16384)));
            else
                pending_items.push_back(make_item(spc_pkg::ACT_SAMPLE, '0, pick_value()));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        ctl_mode = 0;
        ctl_setpoint = 0;
        ctl_delay = 1;
        ctl_a = 0;
        ctl_b = 0;
        ctl_c = 0;
        ctl_weight = 0;
        ctl_dt = 0;
        ring_slot = 0;
        integ = 0;
        prev_err = 0;
        prev_drive = 0;
        for (int i = 0; i < ORDER; i++)
            model_x[i] = 0;
        for (int i = 0; i < DEPTH; i++)
            past_pred[i] = 0;
        for (int i = 0; i < NCOEF; i++)
            coefs[i] = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        write_register(spc_pkg::CFG_MODE, spc_pkg::MODE_PID);
        write_register(spc_pkg::CFG_SETPOINT, 32'h0001_0000);
        write_register(spc_pkg::CFG_DELAY_STEPS, 7'd3);
        write_register(spc_pkg::CFG_COEF_A, 32'h0000_8000);
        write_register(spc_pkg::CFG_COEF_B, 32'h0000_1000);
        write_register(spc_pkg::CFG_COEF_C, 32'h0000_0800);
        write_register(spc_pkg::CFG_SETPOINT_WEIGHT, 32'h0001_0000);
        write_register(spc_pkg::CFG_STEP_DT, 32'h0000_0400);
        pending_items.push_back(make_item(spc_pkg::ACT_SAMPLE, '0, 32'h0000_0000));
        for (int i = 0; i < NCOEF; i++)
            pending_items.push_back(make_item(spc_pkg::ACT_COEF, 5'(i),
                                              32'h0000_2000 + 32'(i * 256)));
        pending_items.push_back(make_item(spc_pkg::ACT_COEF, 5'd31, 32'hffffffff));
        pending_items.push_back(make_item(spc_pkg::ACT_SAMPLE, '0, 32'h7fffffff));
        pending_items.push_back(make_item(spc_pkg::ACT_SAMPLE, '0, 32'h80000000));
        pending_items.push_back(make_item(spc_pkg::ACT_SAMPLE, '0, 32'h0002_0000));
        wait_drained();

        for (int phase = 0; phase < 8; phase++)
        begin
            write_register(spc_pkg::CFG_MODE, 2'(phase % 4));
            write_register(spc_pkg::CFG_SETPOINT, phase == 1 ? 32'h7fffffff :
                           phase == 2 ? 32'h80000000 : pick_value());
            write_register(spc_pkg::CFG_DELAY_STEPS, phase == 3 ? 7'd0 : phase == 4 ? 7'd127 :
                           phase == 5 ? 7'd64 : phase == 6 ? 7'd1 : 7'($urandom_range(1, 64)));
            write_register(spc_pkg::CFG_COEF_A, phase == 2 ? 32'h7fffffff : pick_value());
            write_register(spc_pkg::CFG_COEF_B, phase == 2 ? 32'h80000000 : pick_value());
            write_register(spc_pkg::CFG_COEF_C, pick_value());
            write_register(spc_pkg::CFG_SETPOINT_WEIGHT,
                           phase == 6 ? 32'h80000000 : pick_value());
            write_register(spc_pkg::CFG_STEP_DT, phase == 1 ? 32'h7fffffff :
                           phase == 0 ? 32'h0 : 32'($urandom_range(0, 65536)));
            if (phase == 7)
                calm = 1;
            random_phase(phase == 7 ? 80 : 125);
            wait_drained();
        end
        $display("Checked %0d sample results over eight register settings", samples_checked);
        $display("covering all controller modes, delay extremes and saturation corners.");
        if (errors == 0)
            $display("[smith_predictor_controller_unit] OK");
        else
            $display("[smith_predictor_controller_unit] ERROR");
        $finish;
    end
endmodule

### sim.f
+incdir+rtl/core
rtl/core/spc_pkg.sv
rtl/core/spc_if.sv
rtl/core/spc_ram.sv
rtl/core/spc_mul.sv
rtl/core/smith_predictor_controller_unit.sv
tb/smith_predictor_controller_unit_test.sv
